// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the priority queue RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SSPQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sspq assertion failed");
`define SSPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sspq assertion failed");
`define SSPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sspq assertion failed");
`else
`define SSPQ_ASSERT(label, clk, rst_n, prop)
`define SSPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SSPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/sspq_pkg.sv =====
// Shared sizes, status codes and cell interface types of the priority queue.
// No dependencies; imported by every module of the block.
package sspq_pkg;

    localparam int QUEUE_DEPTH  = 64;
    localparam int PAYLOAD_BITS = 16;
    localparam int KEY_BITS     = 32;
    localparam int COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int STATUS_BITS  = 2;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    // One stored entry as it moves between neighboring cells.
    typedef struct packed {
        logic                    valid;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] data;
    } t_slot;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] data;
    } t_cell_ctrl;

endpackage

// ===== rtl/sspq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares it with a new key
// and shifts toward its neighbors. Depends on sspq_pkg.
module sspq_cell
    import sspq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_slot      i_left,
    input  logic       i_left_take,
    input  t_slot      i_right,
    output t_slot      o_slot,
    output logic       o_take
);

    logic                    r_valid;
    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_data;
    logic                    n_valid;
    logic [KEY_BITS-1:0]     n_key;
    logic [PAYLOAD_BITS-1:0] n_data;

    // A new entry goes ahead of this slot when the slot is empty or holds a
    // strictly larger key, which keeps equal keys in arrival order.
    assign o_take = !r_valid || ($signed(r_key) > $signed(i_ctrl.key));

    assign o_slot.valid = r_valid;
    assign o_slot.key   = r_key;
    assign o_slot.data  = r_data;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_data  = r_data;
        if (i_ctrl.del) begin
            n_valid = i_right.valid;
            n_key   = i_right.key;
            n_data  = i_right.data;
        end else if (i_ctrl.ins && o_take) begin
            if (i_left_take) begin
                n_valid = i_left.valid;
                n_key   = i_left.key;
                n_data  = i_left.data;
            end else begin
                n_valid = 1'b1;
                n_key   = i_ctrl.key;
                n_data  = i_ctrl.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_data <= n_data;
    end

endmodule

// ===== rtl/stable_sorted_priority_queue_core.sv =====
// Top level of the stable sorted priority queue: a chain of sspq_cell slots,
// the occupancy counter and the result register. Depends on sspq_pkg.
//
// Usage: one input channel (i_in_valid / o_in_stall) carries a beat with
// i_mode, i_priority_req and i_payload. Mode insert places the entry after
// all stored entries with a key less than or equal to its own; mode delete
// removes the head entry, the one with the smallest key. Each input beat
// produces exactly one result beat on the output channel
// (o_out_valid / i_out_stall) with o_status, o_out_priority, o_out_payload
// and o_occupancy, the entry count after the operation.
// The result is registered: it appears in the cycle after acceptance.
// Throughput is one beat per cycle unless the output stalls; all slots
// compare with the new key in parallel and shift one place in the same cycle.
// A stalled result holds in the output register, and a new input beat is
// then stalled until the result has been taken.
// Synchronous reset empties the queue and drops any pending result; the
// block takes beats as soon as reset is released.
`include "assert_macros.svh"
module stable_sorted_priority_queue_core
    import sspq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_mode,
    input  logic [KEY_BITS-1:0]     i_priority_req,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [STATUS_BITS-1:0]  o_status,
    output logic [KEY_BITS-1:0]     o_out_priority,
    output logic [PAYLOAD_BITS-1:0] o_out_payload,
    output logic [COUNT_BITS-1:0]   o_occupancy
);

    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(QUEUE_DEPTH);

    logic                    w_accept;
    logic                    w_full;
    logic                    w_empty;
    t_cell_ctrl              w_ctrl;
    t_slot                   w_slot [QUEUE_DEPTH];
    logic                    w_take [QUEUE_DEPTH];

    logic [COUNT_BITS-1:0]   r_count;
    logic [COUNT_BITS-1:0]   n_count;
    logic                    r_out_valid;
    logic                    n_out_valid;
    logic [STATUS_BITS-1:0]  r_status;
    logic [STATUS_BITS-1:0]  n_status;
    logic [KEY_BITS-1:0]     r_out_priority;
    logic [KEY_BITS-1:0]     n_out_priority;
    logic [PAYLOAD_BITS-1:0] r_out_payload;
    logic [PAYLOAD_BITS-1:0] n_out_payload;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == FULL_COUNT);
    assign w_empty    = (r_count == '0);

    assign w_ctrl.ins  = w_accept && (i_mode == MODE_INSERT) && !w_full;
    assign w_ctrl.del  = w_accept && (i_mode == MODE_DELETE) && !w_empty;
    assign w_ctrl.key  = i_priority_req;
    assign w_ctrl.data = i_payload;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_left_take;

        if (g == 0) begin : g_head
            assign w_left      = '0;
            assign w_left_take = 1'b0;
        end else begin : g_mid
            assign w_left      = w_slot[g-1];
            assign w_left_take = w_take[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_slot[g+1];
        end

        sspq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_left      (w_left),
            .i_left_take (w_left_take),
            .i_right     (w_right),
            .o_slot      (w_slot[g]),
            .o_take      (w_take[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_ctrl.del) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_out_valid    = r_out_valid && i_out_stall;
        n_status       = r_status;
        n_out_priority = r_out_priority;
        n_out_payload  = r_out_payload;
        if (w_accept) begin
            n_out_valid    = 1'b1;
            n_status       = ST_OK;
            n_out_priority = '0;
            n_out_payload  = '0;
            if (i_mode == MODE_DELETE) begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_out_priority = w_slot[0].key;
                    n_out_payload  = w_slot[0].data;
                end
            end else if (w_full) begin
                n_status = ST_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status       <= n_status;
        r_out_priority <= n_out_priority;
        r_out_payload  <= n_out_payload;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_priority = r_out_priority;
    assign o_out_payload  = r_out_payload;
    assign o_occupancy    = r_count;

    `SSPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_COUNT)
    `SSPQ_ASSERT(a_head_matches_count, i_clk, i_rst_n, w_slot[0].valid == !w_empty)
    `SSPQ_ASSERT_IMPLY(a_head_sorted, i_clk, i_rst_n, w_slot[1].valid,
        $signed(w_slot[0].key) <= $signed(w_slot[1].key))
    `SSPQ_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_ctrl.ins,
        r_count == $past(r_count) + 1'b1 && o_out_valid && o_status == ST_OK)
    `SSPQ_ASSERT_NEXT(a_occupancy_reported, i_clk, i_rst_n, w_accept,
        o_occupancy == r_count)

endmodule
